// ===== rtl/c8rng_pkg.sv =====
// Shared types, constants and helper functions for the ChaCha8 random generator.
package c8rng_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] cc_state_t;
	typedef word_t [7:0] key_t;

	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_RESEED = 2'd1,
		ACT_WYRAND = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_FEED,
		S_PICK,
		S_WY_START,
		S_WY_WAIT,
		S_DONE
	} seq_state_t;

	localparam int DOUBLE_ROUNDS_DEF = 4;

	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;
	localparam word_t KEY_STEP = 32'h9e3779b9;

	localparam logic [63:0] WY_ADD_C = 64'ha0761d6478bd642f;
	localparam logic [63:0] WY_XOR_C = 64'he7037ed1a0b428db;
	localparam logic [63:0] SEED_RESET = 64'h1234567890abcdef;

	function automatic word_t key_tweak(input int i);
		return word_t'(32'(i) * KEY_STEP);
	endfunction

	function automatic word_t rot_step(input logic [1:0] step, input word_t x);
		word_t r;
		unique case (step)
			2'd0: r = {x[15:0], x[31:16]};
			2'd1: r = {x[19:0], x[31:20]};
			2'd2: r = {x[23:0], x[31:24]};
			default: r = {x[24:0], x[31:25]};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/chacha8_random_generator.sv =====
// Top level of the ChaCha8 random generator: sequencer, generator state and output register.
//
// Each transfer carries one action. A reseed loads the seed and key on its transfer and gives
// no result. A ChaCha draw from a filled buffer passes through S_PICK and S_DONE before its
// result is shown. A draw that finds the buffer empty first computes a new block. The shared
// round unit advances all four columns or diagonals by one quarter-round step per cycle in
// S_ROUND; that draw then passes through S_FEED, S_PICK and S_DONE and refills eight words.
// A wyrand draw passes through S_WY_START, S_WY_WAIT and S_DONE, where S_WY_WAIT waits on the
// four passes through the single 32x32 multiplier. The input is stalled while an action is in
// work and is ready again in the cycle the result appears. A finished result waits in the
// output register while the next transfer is taken.
module chacha8_random_generator #(
	parameter int DOUBLE_ROUNDS = c8rng_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] seed_value,
	input  logic [3:0]  seed_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] random_word
);
	import c8rng_pkg::*;

	localparam int STEPS = DOUBLE_ROUNDS * 8;
	localparam int CW = $clog2(STEPS);

	seq_state_t  state_q, state_d;
	logic [63:0] seed_q;
	key_t        key_q;
	word_t       ctr_q;
	logic [3:0]  idx_q;
	cc_state_t   st_q;
	cc_state_t   qr_nxt;
	cc_state_t   init_w;
	logic [CW-1:0] rnd_q;
	logic [63:0] res_q;
	logic        out_valid_q;
	logic [63:0] random_word_q;
	logic        in_fire;
	logic        out_free;
	logic [63:0] new_seed;
	key_t        new_key;
	logic [63:0] pick_word;
	logic        wy_start;
	logic        wy_done;
	logic [63:0] wy_mix;

	assign in_fire = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	c8rng_qr_unit u_qr (
		.st   (st_q),
		.step (rnd_q[1:0]),
		.diag (rnd_q[2]),
		.nxt  (qr_nxt)
	);

	c8rng_wymul u_wymul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wy_start),
		.op_a   (seed_q),
		.op_b   (seed_q ^ WY_XOR_C),
		.done   (wy_done),
		.mix    (wy_mix)
	);

	always_comb begin
		new_seed = seed_q;
		for (int k = 0; k < 8; k++) begin
			if (seed_len >= 4'(k + 1)) begin
				new_seed[8*k +: 8] = seed_value[8*k +: 8];
			end
		end
		for (int i = 0; i < 8; i++) begin
			new_key[i] = ((i % 2) == 1 ? new_seed[63:32] : new_seed[31:0]) ^ key_tweak(i);
		end
		init_w[0] = SIGMA0;
		init_w[1] = SIGMA1;
		init_w[2] = SIGMA2;
		init_w[3] = SIGMA3;
		for (int i = 0; i < 8; i++) begin
			init_w[4 + i] = key_q[i];
		end
		init_w[12] = ctr_q;
		init_w[13] = '0;
		init_w[14] = '0;
		init_w[15] = '0;
		pick_word = {st_q[{idx_q[2:0], 1'b1}], st_q[{idx_q[2:0], 1'b0}]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		wy_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (action)
						ACT_DRAW: state_d = idx_q[3] ? S_ROUND : S_PICK;
						ACT_WYRAND: state_d = S_WY_START;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ROUND: begin
				if (rnd_q == CW'(STEPS - 1)) begin
					state_d = S_FEED;
				end
			end
			S_FEED: state_d = S_PICK;
			S_PICK: state_d = S_DONE;
			S_WY_START: begin
				wy_start = 1'b1;
				state_d = S_WY_WAIT;
			end
			S_WY_WAIT: begin
				if (wy_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			key_q <= '0;
			ctr_q <= '0;
			idx_q <= 4'd8;
			rnd_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					rnd_q <= '0;
					if (in_fire) begin
						unique case (action)
							ACT_RESEED: begin
								seed_q <= new_seed;
								key_q <= new_key;
								idx_q <= 4'd8;
							end
							ACT_WYRAND: seed_q <= seed_q + WY_ADD_C;
							default: ;
						endcase
					end
				end
				S_ROUND: rnd_q <= rnd_q + CW'(1);
				S_FEED: begin
					ctr_q <= ctr_q + 32'd1;
					idx_q <= 4'd0;
				end
				S_PICK: idx_q <= idx_q + 4'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && action == ACT_DRAW && idx_q[3]) begin
					st_q <= init_w;
				end
			end
			S_ROUND: st_q <= qr_nxt;
			S_FEED: begin
				for (int i = 0; i < 16; i++) begin
					st_q[i] <= st_q[i] + init_w[i];
				end
			end
			S_PICK: res_q <= pick_word;
			S_WY_WAIT: begin
				if (wy_done) begin
					res_q <= wy_mix;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			random_word_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign random_word = random_word_q;

endmodule

// ===== rtl/c8rng_qr_unit.sv =====
// Shared add-xor-rotate unit that advances four quarter rounds by one step.
module c8rng_qr_unit (
	input  c8rng_pkg::cc_state_t st,
	input  logic [1:0]           step,
	input  logic                 diag,
	output c8rng_pkg::cc_state_t nxt
);
	import c8rng_pkg::*;

	always_comb begin
		logic [3:0] ia, ib, ic, id, ip, iq, ir;
		word_t sum;
		nxt = st;
		for (int j = 0; j < 4; j++) begin
			ia = 4'(j);
			ib = diag ? 4'(4 + ((j + 1) % 4)) : 4'(4 + j);
			ic = diag ? 4'(8 + ((j + 2) % 4)) : 4'(8 + j);
			id = diag ? 4'(12 + ((j + 3) % 4)) : 4'(12 + j);
			ip = step[0] ? ic : ia;
			iq = step[0] ? id : ib;
			ir = step[0] ? ib : id;
			sum = st[ip] + st[iq];
			nxt[ip] = sum;
			nxt[ir] = rot_step(step, st[ir] ^ sum);
		end
	end

endmodule

// ===== rtl/c8rng_wymul.sv =====
// Wyrand mixer: 64x64 product built from four 32x32 partial products, low half xor high half.
module c8rng_wymul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output logic        done,
	output logic [63:0] mix
);
	import c8rng_pkg::*;

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic         vld_s1;
	logic         last_s1;
	word_t        mul_a, mul_b;
	logic [1:0]   mul_sh;
	logic [127:0] addend;

	always_comb begin
		unique case (cnt_q)
			2'd0: begin
				mul_a = a_q[31:0];
				mul_b = b_q[31:0];
				mul_sh = 2'd0;
			end
			2'd1: begin
				mul_a = a_q[31:0];
				mul_b = b_q[63:32];
				mul_sh = 2'd1;
			end
			2'd2: begin
				mul_a = a_q[63:32];
				mul_b = b_q[31:0];
				mul_sh = 2'd1;
			end
			default: begin
				mul_a = a_q[63:32];
				mul_b = b_q[63:32];
				mul_sh = 2'd2;
			end
		endcase
		addend = {64'd0, prod_s1} << {sh_s1, 5'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 2'd0;
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1 && last_s1;
			vld_s1 <= run_q;
			last_s1 <= run_q && (cnt_q == 2'd3);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end
		prod_s1 <= {32'd0, mul_a} * {32'd0, mul_b};
		sh_s1 <= mul_sh;
		if (start) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign done = done_q;
	assign mix = acc_q[63:0] ^ acc_q[127:64];

endmodule

// ===== rtl/c8rng_checker.sv =====
// Port-level checks for the ChaCha8 random generator and the bind that attaches them.
module c8rng_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] random_word
);
	import c8rng_pkg::*;

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_word);
	endproperty
	a_out_hold: assert property (p_out_hold)
		else $error("Stalled output transfer changed.");

	property p_draw_busy;
		@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_DRAW || action == ACT_WYRAND) |=> in_stall;
	endproperty
	a_draw_busy: assert property (p_draw_busy)
		else $error("Input was not stalled after a draw transfer.");

	property p_reseed_silent;
		@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_RESEED && !out_valid |=> !out_valid;
	endproperty
	a_reseed_silent: assert property (p_reseed_silent)
		else $error("A reseed produced an output transfer.");

	property p_result_from_work;
		@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall);
	endproperty
	a_result_from_work: assert property (p_result_from_work)
		else $error("A result appeared without an action in work.");

endmodule

bind chacha8_random_generator c8rng_checker u_c8rng_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.action      (action),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.random_word (random_word)
);

// ===== sim/chacha8_random_generator_tb.sv =====
// Self-checking testbench for the ChaCha8 and wyrand random generator with a cycle-free predictor.
`timescale 1ns / 100ps

module chacha8_random_generator_tb;
	import c8rng_pkg::*;

	localparam int DBL_ROUNDS = DOUBLE_ROUNDS_DEF;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG = 3000;

	typedef struct packed {
		logic [1:0]  act;
		logic [63:0] value;
		logic [3:0]  len;
	} item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_DRAW;
	logic [63:0] seed_value = '0;
	logic [3:0]  seed_len = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] random_word;

	item_t       pending[$];
	logic [63:0] words_due[$];
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_cnt = 0;
	int          quiet = 0;
	int          errors = 0;
	int          n_draw = 0, n_wy = 0, n_reseed = 0, n_ignored = 0, n_blocks = 0, n_checked = 0;

	logic [63:0] gen_seed = SEED_RESET;
	word_t       gen_key[8] = '{default: '0};
	word_t       gen_ctr = '0;
	logic [63:0] gen_buf[8];
	logic [3:0]  word_pos = 4'd8;

	chacha8_random_generator #(.DOUBLE_ROUNDS(DBL_ROUNDS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.seed_value(seed_value),
		.seed_len(seed_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.random_word(random_word)
	);

	always #1 clk = ~clk;

	function automatic word_t rotl(input word_t x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic cc_state_t qround(input cc_state_t s, input int a, b, c, d);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
		return s;
	endfunction

	function automatic void refill_block();
		cc_state_t init;
		cc_state_t w;
		int i;
		init[0] = SIGMA0;
		init[1] = SIGMA1;
		init[2] = SIGMA2;
		init[3] = SIGMA3;
		for (i = 0; i < 8; i++) init[4 + i] = gen_key[i];
		init[12] = gen_ctr;
		init[13] = '0;
		init[14] = '0;
		init[15] = '0;
		w = init;
		for (i = 0; i < DBL_ROUNDS; i++) begin
			w = qround(w, 0, 4, 8, 12);
			w = qround(w, 1, 5, 9, 13);
			w = qround(w, 2, 6, 10, 14);
			w = qround(w, 3, 7, 11, 15);
			w = qround(w, 0, 5, 10, 15);
			w = qround(w, 1, 6, 11, 12);
			w = qround(w, 2, 7, 8, 13);
			w = qround(w, 3, 4, 9, 14);
		end
		for (i = 0; i < 16; i++) w[i] = w[i] + init[i];
		for (i = 0; i < 8; i++) gen_buf[i] = {w[2 * i + 1], w[2 * i]};
		gen_ctr = gen_ctr + 32'd1;
		n_blocks++;
	endfunction

	function automatic bit predict_word(input logic [1:0] act, input logic [63:0] value,
			input logic [3:0] len, output logic [63:0] word);
		logic [127:0] prod;
		int i;
		word = '0;
		case (act)
			ACT_DRAW: begin
				n_draw++;
				if (word_pos >= 4'd8) begin
					refill_block();
					word_pos = 4'd0;
				end
				word = gen_buf[word_pos[2:0]];
				word_pos = word_pos + 4'd1;
				return 1'b1;
			end
			ACT_RESEED: begin
				n_reseed++;
				if (len >= 4'd8) gen_seed = value;
				else for (i = 0; i < len; i++) gen_seed[8 * i +: 8] = value[8 * i +: 8];
				for (i = 0; i < 8; i++)
					gen_key[i] = (i % 2 == 1 ? gen_seed[63:32] : gen_seed[31:0])
						^ (word_t'(i) * KEY_STEP);
				word_pos = 4'd8;
				return 1'b0;
			end
			ACT_WYRAND: begin
				n_wy++;
				gen_seed = gen_seed + WY_ADD_C;
				prod = {64'd0, gen_seed} * {64'd0, gen_seed ^ WY_XOR_C};
				word = prod[63:0] ^ prod[127:64];
				return 1'b1;
			end
			default: begin
				n_ignored++;
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk) begin : drive
		item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
				nxt = pending.pop_front();
				in_valid <= 1'b1;
				action <= nxt.act;
				seed_value <= nxt.value;
				seed_len <= nxt.len;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt <= 0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_cnt <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(99) < 35;
		end
	end

	always @(posedge clk) begin : watch
		logic [63:0] w;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (predict_word(action, seed_value, seed_len, w)) words_due.push_back(w);
			end
			if (out_valid && !out_stall) begin
				if (words_due.size() == 0) begin
					errors++;
					$display("%0t: random_word expected none, got %h", $time, random_word);
				end else begin
					w = words_due.pop_front();
					n_checked++;
					if (random_word !== w) begin
						errors++;
						$display("%0t: random_word expected %h, got %h", $time, w, random_word);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == WATCHDOG) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [1:0] act, input logic [63:0] value,
			input logic [3:0] len);
		item_t it;
		it.act = act;
		it.value = value;
		it.len = len;
		pending.push_back(it);
	endtask

	task automatic queue_random(input int count);
		int done;
		int r;
		int k;
		logic [63:0] v;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			if ($urandom_range(3) == 0) v = $urandom_range(1) ? '1 : '0;
			else v = {$urandom, $urandom};
			if (r < 20) begin
				for (k = $urandom_range(4, 17); k > 0 && done < count; k--) begin
					push_item(ACT_DRAW, {$urandom, $urandom}, 4'($urandom_range(15)));
					done++;
				end
			end else if (r < 60) begin
				push_item(ACT_DRAW, v, 4'($urandom_range(15)));
				done++;
			end else if (r < 76) begin
				push_item(ACT_WYRAND, v, 4'($urandom_range(15)));
				done++;
			end else if (r < 93) begin
				push_item(ACT_RESEED, v, 4'($urandom_range(15)));
				done++;
			end else begin
				push_item(ACT_UNUSED, v, 4'($urandom_range(15)));
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending.size() != 0 || in_valid || words_due.size() != 0);
	endtask

	initial begin : stimulus
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < 9; k++) push_item(ACT_DRAW, '0, '0);
		push_item(ACT_WYRAND, '0, '0);
		push_item(ACT_RESEED, '1, 4'd0);
		push_item(ACT_DRAW, '0, '0);
		push_item(ACT_RESEED, '1, 4'd8);
		push_item(ACT_DRAW, '1, '1);
		push_item(ACT_WYRAND, '0, '0);
		push_item(ACT_RESEED, '0, 4'd15);
		push_item(ACT_DRAW, '0, '0);
		push_item(ACT_WYRAND, '1, '1);
		push_item(ACT_RESEED, 64'ha5a5a5a55a5a5a5a, 4'd3);
		push_item(ACT_DRAW, '0, '0);
		push_item(ACT_DRAW, '0, '0);
		push_item(ACT_UNUSED, '1, 4'd15);
		push_item(ACT_RESEED, {$urandom, $urandom}, 4'd7);
		push_item(ACT_WYRAND, '0, '0);
		push_item(ACT_DRAW, '0, '0);
		wait_drained();

		queue_random(150);
		wait_drained();

		for (k = 0; k < 40; k++) push_item(k % 5 == 4 ? ACT_WYRAND : ACT_DRAW, '0, '0);
		@(negedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		wait_drained();
		repeat ($urandom_range(5, 25)) @(negedge clk);

		calm = 1'b1;
		queue_random(120);
		wait_drained();
		calm = 1'b0;

		queue_random(240);
		wait_drained();
		repeat (60) @(negedge clk);

		$display("covered %0d draws over %0d blocks, %0d wyrand draws, %0d reseeds, %0d ignored",
			n_draw, n_blocks, n_wy, n_reseed, n_ignored);
		$display("checked %0d results, %0d mismatches", n_checked, errors);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/c8rng_pkg.sv
rtl/c8rng_qr_unit.sv
rtl/c8rng_wymul.sv
rtl/chacha8_random_generator.sv
rtl/c8rng_checker.sv
sim/chacha8_random_generator_tb.sv
